// ----- rtl/gcf_pkg.sv -----
// gcf_pkg: shared types, constants and helpers for the graph cycle finder.
// Used by gcf_lane, gcf_merge and graph_cycle_finder; depends on nothing.

package gcf_pkg;

    localparam int MAX_NODES_DEF = 16;          // default node capacity
    localparam int ROW_W         = 16;          // adjacency row width
    localparam int ROW_IW        = $clog2(ROW_W);
    localparam int CFG_W         = 5;           // node_count register width
    localparam int VERT_W        = 5;           // vertex / length field width
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(16);

    typedef logic [ROW_W-1:0] t_row;

    typedef enum logic [2:0] {
        S_LOAD,     // taking rows
        S_ROOT,     // pick next unvisited root
        S_SCAN,     // depth-first step: descend, close or back up
        S_WALK,     // climb parents from current node to closing node
        S_EMIT,     // hand out cycle vertices
        S_NONE      // hand out the no-cycle beat
    } t_state;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic cand;     // lane node is the next eligible neighbour candidate
        logic root;     // lane node is an unvisited node in range
    } t_lane_res;

    // bit b of a row, zero outside the row
    function automatic logic row_bit(t_row r, int b);
        if (b >= 0 && b < ROW_W) begin
            return r[b[ROW_IW-1:0]];
        end
        return 1'b0;
    endfunction

endpackage

// ----- rtl/gcf_lane.sv -----
// gcf_lane: one lane per graph node; judges whether its node is an edge
// candidate of the current node and whether it can serve as a new root.
// Depends on gcf_pkg.

module gcf_lane #(
    parameter int LANE = 1,      // node number of this lane, from 1
    parameter int NW   = 5,      // width of a node number
    parameter int NXW  = 5       // width of the scan position
) (
    input  gcf_pkg::t_row      i_row_u,     // row of the current node
    input  gcf_pkg::t_row      i_row_own,   // row of this lane's node
    input  logic [NW-1:0]      i_cur,
    input  logic [NW-1:0]      i_parent,
    input  logic [NXW-1:0]     i_next,
    input  logic [NW-1:0]      i_n,
    input  logic               i_visited,
    output gcf_pkg::t_lane_res o_res
);
    import gcf_pkg::*;

    logic w_edge;
    logic w_in_range;

    // matrix taken as symmetric: either row naming the edge counts
    assign w_edge     = row_bit(i_row_u, LANE - 1) | row_bit(i_row_own, int'(i_cur) - 1);
    assign w_in_range = (LANE <= int'(i_n));

    assign o_res.cand = w_edge && w_in_range && (LANE >= int'(i_next))
                        && (LANE != int'(i_parent));
    assign o_res.root = !i_visited && w_in_range;

endmodule

// ----- rtl/gcf_merge.sv -----
// gcf_merge: merge stage over the lane requests; picks the lowest-numbered
// requesting node. Depends on gcf_pkg for house style only.

module gcf_merge #(
    parameter int LANES = 16,
    parameter int NW    = 5
) (
    input  logic [LANES-1:0] i_req,
    output logic             o_any,
    output logic [NW-1:0]    o_node     // winning node number, from 1
);
    import gcf_pkg::*;

    always_comb begin
        o_any  = 1'b0;
        o_node = '0;
        // scan from the top so the lowest request wins
        for (int k = LANES - 1; k >= 0; k--) begin
            if (i_req[k]) begin
                o_any  = 1'b1;
                o_node = NW'(k + 1);
            end
        end
    end

endmodule

// ----- rtl/graph_cycle_finder.sv -----
// graph_cycle_finder: depth-first cycle detection on an undirected graph
// given as adjacency rows. Top level; depends on gcf_pkg, gcf_lane, gcf_merge.
//
// Usage:
//  Input channel (i_valid / o_stall): one adjacency row per beat, node 1 first.
//  Rows are taken one per cycle while the block is loading; o_stall rises once
//  the last row of a graph (node_count rows) is in and stays high until every
//  result beat of that graph has been placed in the output register.
//  Output channel (o_valid / i_stall): one beat per cycle vertex, closing node
//  first, last_of_run on the final one; a graph without a cycle gives a single
//  beat with cycle_found low.
//  After the last row, the search descends edges, backs up and picks roots in
//  lane-parallel steps; it then climbs the parent chain from the current node
//  to the closing node and hands out the result beats.
//  The search step rate is set by one parent-table read and one priority pick
//  over all lanes per cycle.
//  A stalled receiver holds the output register; emission waits, loading of
//  the next graph resumes only after the last beat is registered.
//  Config: i_cfg_we writes node_count and restarts the row count; write only
//  while idle. Synchronous active-low reset: node_count 16, no rows held.

module graph_cycle_finder #(
    parameter int MAX_NODES = gcf_pkg::MAX_NODES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [gcf_pkg::CFG_W-1:0] i_cfg_data,
    // row input
    input  logic                      i_valid,
    output logic                      o_stall,
    input  gcf_pkg::t_row             i_adjacency_row,
    // result output
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_cycle_found,
    output logic [gcf_pkg::VERT_W-1:0] o_cycle_length,
    output logic [gcf_pkg::VERT_W-1:0] o_cycle_vertex,
    output logic                      o_last_of_run
);
    import gcf_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);   // node number 0..MAX
    localparam int NXW = $clog2(MAX_NODES + 2);   // scan position 1..MAX+1
    localparam int IW  = $clog2(MAX_NODES);       // store index

    // state
    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_node_count;
    logic [NW-1:0]        r_rows_loaded;
    t_row                 r_rows [MAX_NODES];
    logic [MAX_NODES-1:0] r_visited;
    logic [NW-1:0]        r_parent [MAX_NODES];
    logic [NW-1:0]        r_chain [MAX_NODES];
    logic [NW-1:0]        r_cur;
    logic [NXW-1:0]       r_next;
    logic [NW-1:0]        r_close;
    logic [NW-1:0]        r_walk;
    logic [NW-1:0]        r_count;
    logic [NW-1:0]        r_k;

    // output register
    logic                 r_o_valid;
    logic                 r_o_found;
    logic [VERT_W-1:0]    r_o_len;
    logic [VERT_W-1:0]    r_o_vertex;
    logic                 r_o_last;

    // combinational
    logic [NW-1:0]        w_n;
    logic [NW-1:0]        w_load_idx;
    logic [NW-1:0]        w_load_cnt;
    logic                 w_accept_in;
    logic                 w_out_free;
    logic [NW-1:0]        w_par_addr;
    logic [NW-1:0]        w_par;
    t_row                 w_row_u;
    t_lane_res            w_lane [MAX_NODES];
    logic [MAX_NODES-1:0] w_cand_req;
    logic [MAX_NODES-1:0] w_root_req;
    logic                 w_cand_any;
    logic [NW-1:0]        w_cand_node;
    logic                 w_root_any;
    logic [NW-1:0]        w_root_node;
    logic                 w_cand_vis;
    logic                 w_walk_go;
    logic                 w_emit_last;
    logic [NW-1:0]        w_emit_vertex;
    logic                 w_last_row;

    // effective node count: 0 acts as 1, capped at capacity
    always_comb begin
        if (r_node_count == '0) begin
            w_n = NW'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            w_n = NW'(MAX_NODES);
        end else begin
            w_n = NW'(r_node_count);
        end
    end

    assign w_load_idx  = (r_rows_loaded >= w_n) ? '0 : r_rows_loaded;
    assign w_load_cnt  = w_load_idx + NW'(1);
    assign w_last_row  = (w_load_cnt == w_n);
    assign o_stall     = (r_state != S_LOAD);
    assign w_accept_in = i_valid && !o_stall;
    assign w_out_free  = !r_o_valid || !i_stall;

    // one parent read port, shared between search and climb
    assign w_par_addr = (r_state == S_WALK) ? r_walk : r_cur;
    assign w_par      = r_parent[IW'(w_par_addr - NW'(1))];
    assign w_row_u    = r_rows[IW'(r_cur - NW'(1))];

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_lane
        gcf_lane #(
            .LANE (g + 1),
            .NW   (NW),
            .NXW  (NXW)
        ) u_lane (
            .i_row_u   (w_row_u),
            .i_row_own (r_rows[g]),
            .i_cur     (r_cur),
            .i_parent  (w_par),
            .i_next    (r_next),
            .i_n       (w_n),
            .i_visited (r_visited[g]),
            .o_res     (w_lane[g])
        );
        assign w_cand_req[g] = w_lane[g].cand;
        assign w_root_req[g] = w_lane[g].root;
    end

    gcf_merge #(
        .LANES (MAX_NODES),
        .NW    (NW)
    ) u_merge_cand (
        .i_req  (w_cand_req),
        .o_any  (w_cand_any),
        .o_node (w_cand_node)
    );

    gcf_merge #(
        .LANES (MAX_NODES),
        .NW    (NW)
    ) u_merge_root (
        .i_req  (w_root_req),
        .o_any  (w_root_any),
        .o_node (w_root_node)
    );

    assign w_cand_vis    = r_visited[IW'(w_cand_node - NW'(1))];
    assign w_walk_go     = (r_walk != r_close) && (r_walk != '0) && (r_count < w_n - NW'(1));
    assign w_emit_last   = (r_k == r_count);
    assign w_emit_vertex = (r_k == '0) ? r_close : r_chain[IW'(r_count - r_k)];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept_in && w_last_row) n_state = S_ROOT;
            end
            S_ROOT: begin
                n_state = w_root_any ? S_SCAN : S_NONE;
            end
            S_SCAN: begin
                if (w_cand_any) begin
                    if (w_cand_vis) n_state = S_WALK;
                end else if (w_par == '0) begin
                    n_state = S_ROOT;
                end
            end
            S_WALK: begin
                if (!w_walk_go) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) n_state = S_LOAD;
            end
            S_NONE: begin
                if (w_out_free) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_node_count  <= NODE_COUNT_RST;
            r_rows_loaded <= '0;
            r_visited     <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_node_count  <= i_cfg_data;
                r_rows_loaded <= '0;
            end else if (w_accept_in) begin
                r_rows_loaded <= w_last_row ? '0 : w_load_cnt;
            end
            if (w_accept_in && w_last_row) begin
                r_visited <= '0;
            end else if (r_state == S_ROOT && w_root_any) begin
                r_visited[IW'(w_root_node - NW'(1))] <= 1'b1;
            end else if (r_state == S_SCAN && w_cand_any && !w_cand_vis) begin
                r_visited[IW'(w_cand_node - NW'(1))] <= 1'b1;
            end
            if ((r_state == S_EMIT || r_state == S_NONE) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (w_accept_in) r_rows[IW'(w_load_idx)] <= i_adjacency_row;
            end
            S_ROOT: begin
                if (w_root_any) begin
                    r_cur <= w_root_node;
                    r_parent[IW'(w_root_node - NW'(1))] <= '0;
                    r_next <= NXW'(1);
                end
            end
            S_SCAN: begin
                if (w_cand_any) begin
                    if (w_cand_vis) begin
                        r_close <= w_cand_node;
                        r_walk  <= r_cur;
                        r_count <= '0;
                    end else begin
                        r_parent[IW'(w_cand_node - NW'(1))] <= r_cur;
                        r_cur  <= w_cand_node;
                        r_next <= NXW'(1);
                    end
                end else if (w_par != '0) begin
                    // back up: resume the parent just past this child
                    r_cur  <= w_par;
                    r_next <= NXW'(r_cur) + NXW'(1);
                end
            end
            S_WALK: begin
                if (w_walk_go) begin
                    r_chain[IW'(r_count)] <= r_walk;
                    r_walk  <= w_par;
                    r_count <= r_count + NW'(1);
                end else begin
                    r_k <= '0;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_o_found  <= 1'b1;
                    r_o_len    <= VERT_W'(r_count + NW'(1));
                    r_o_vertex <= VERT_W'(w_emit_vertex);
                    r_o_last   <= w_emit_last;
                    r_k        <= r_k + NW'(1);
                end
            end
            S_NONE: begin
                if (w_out_free) begin
                    r_o_found  <= 1'b0;
                    r_o_len    <= '0;
                    r_o_vertex <= '0;
                    r_o_last   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid        = r_o_valid;
    assign o_cycle_found  = r_o_found;
    assign o_cycle_length = r_o_len;
    assign o_cycle_vertex = r_o_vertex;
    assign o_last_of_run  = r_o_last;

endmodule
